/* hdl/circular_mean_accumulator_core_macros.svh */
// ----------------------------------------------------------------------------
// Circular mean accumulator assertion macros
// Shared property forms for the block's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_MEAN_ACCUMULATOR_CORE_MACROS_SVH
`define CIRCULAR_MEAN_ACCUMULATOR_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define CMA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define CMA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/cma_pkg.sv */
// ----------------------------------------------------------------------------
// Circular mean accumulator package
// Payload types, control structs, sequencer states and widths.
// ----------------------------------------------------------------------------
`default_nettype none

package cma_pkg;

  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned SUM_W       = 32;
  localparam int unsigned COUNT_W     = 16;
  localparam int unsigned PROD_W      = SUM_W + COUNT_W;
  localparam int unsigned DIVIDEND_W  = SUM_W + 2;
  localparam int unsigned DIVISOR_W   = COUNT_W + 1;
  localparam int unsigned DIV_CNT_W   = $clog2(DIVIDEND_W + 1);

  localparam logic [COUNT_W-1:0]  MAX_SAMPLES   = 16'hFFFF;
  localparam logic [SAMPLE_W-1:0] MODULUS_RESET = 16'd360;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                sample_accepted;
    logic                end_of_window;
  } cma_in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] mean_value;
    logic                mean_missing;
  } cma_out_t;

  typedef struct packed {
    logic                integrate;
    logic                clear;
    logic [SAMPLE_W-1:0] sample;
  } cma_acc_ctl_t;

  typedef struct packed {
    logic [SUM_W-1:0]   low_sum;
    logic [SUM_W-1:0]   high_sum;
    logic [COUNT_W-1:0] low_count;
    logic [COUNT_W-1:0] high_count;
  } cma_acc_sts_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_MUL_HL,
    S_MUL_LH,
    S_MUL_MH,
    S_MUL_MHL,
    S_CMP,
    S_ADDM,
    S_DIV,
    S_OUT
  } cma_state_t;

endpackage

`default_nettype wire

/* hdl/cma_accum.sv */
// ----------------------------------------------------------------------------
// Circular mean accumulator: group store
// Low and high group sums and saturating counts, split at half the modulus.
// ----------------------------------------------------------------------------
`default_nettype none

module cma_accum (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire cma_pkg::cma_acc_ctl_t          ctl,
  input  wire logic [cma_pkg::SAMPLE_W-1:0]   modulus,
  output cma_pkg::cma_acc_sts_t               sts
);
  import cma_pkg::*;

  cma_acc_sts_t acc_r;
  cma_acc_sts_t acc_nxt;
  logic         is_low;

  // exact half-period split: 2*s < m
  assign is_low = {ctl.sample, 1'b0} < {1'b0, modulus};

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clear) begin
      acc_nxt = '0;
    end else if (ctl.integrate) begin
      if (is_low) begin
        if (acc_r.low_count != MAX_SAMPLES) begin
          acc_nxt.low_count = acc_r.low_count + 1'b1;
          acc_nxt.low_sum   = acc_r.low_sum + {{(SUM_W-SAMPLE_W){1'b0}}, ctl.sample};
        end
      end else begin
        if (acc_r.high_count != MAX_SAMPLES) begin
          acc_nxt.high_count = acc_r.high_count + 1'b1;
          acc_nxt.high_sum   = acc_r.high_sum + {{(SUM_W-SAMPLE_W){1'b0}}, ctl.sample};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign sts = acc_r;

endmodule

`default_nettype wire

/* hdl/cma_div.sv */
// ----------------------------------------------------------------------------
// Circular mean accumulator: divider
// Restoring shift-subtract divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cma_div (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic [cma_pkg::DIVIDEND_W-1:0]   dividend,
  input  wire logic [cma_pkg::DIVISOR_W-1:0]    divisor,
  output logic                                  busy,
  output logic                                  done,
  output logic [cma_pkg::DIVIDEND_W-1:0]        quotient
);
  import cma_pkg::*;

  logic                  busy_r;
  logic                  done_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVISOR_W-1:0]  div_r;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    shifted;

  assign shifted = {rem_r, quo_r[DIVIDEND_W-1]};
  assign trial   = shifted - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIVIDEND_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      // remainder stays below divisor, so the top trial bit is the borrow
      if (!trial[DIVISOR_W]) begin
        rem_r <= trial[DIVISOR_W-1:0];
        quo_r <= {quo_r[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[DIVISOR_W-1:0];
        quo_r <= {quo_r[DIVIDEND_W-2:0], 1'b0};
      end
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

/* hdl/circular_mean_accumulator_core.sv */
// ----------------------------------------------------------------------------
// Circular mean accumulator core
// Mean of modular samples over a window, with one-period unwrap of the low group.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one item per accept: a sample, its accept
//   flag and an end-of-window mark. Items without end-of-window are absorbed
//   while idle, so such items stream at one per cycle outside a result sequence.
//   An end-of-window item starts the result sequence and in_stall stays high
//   until the result is loaded into the output register. The sequence uses one
//   32x16 multiplier and one 34/17-bit restoring divider:
//     missing result: no multiply or divide step
//     one group empty: divider only
//     both groups present: 5-6 multiply/compare/add steps, then the divider
//   out_valid/out_stall/out_data present the result from a register; a held
//   result blocks the load of the next result; input stalls only behind that load.
//   cfg_wr_en/cfg_wr_data write the modulus; write only while idle.
//   Reset (rst_n low, synchronous) clears sums, counts and the output valid
//   and sets the modulus to 360.
// ----------------------------------------------------------------------------
`default_nettype none

`include "circular_mean_accumulator_core_macros.svh"

module circular_mean_accumulator_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire cma_pkg::cma_in_t              in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output cma_pkg::cma_out_t                  out_data,
  input  wire logic                          cfg_wr_en,
  input  wire logic [cma_pkg::SAMPLE_W-1:0]  cfg_wr_data
);
  import cma_pkg::*;

  cma_state_t            state_r;
  cma_state_t            state_nxt;
  logic [SAMPLE_W-1:0]   modulus_r;

  cma_acc_ctl_t          acc_ctl;
  cma_acc_sts_t          acc_sts;

  logic                  div_start;
  logic [DIVIDEND_W-1:0] div_dividend;
  logic [DIVISOR_W-1:0]  div_divisor;
  logic                  div_busy;
  logic                  div_done;
  logic [DIVIDEND_W-1:0] div_quotient;

  logic [SUM_W-1:0]      mul_a;
  logic [COUNT_W-1:0]    mul_b;
  logic [PROD_W-1:0]     prod_r;
  logic [PROD_W-1:0]     a_r;
  logic [PROD_W-1:0]     diff_r;
  logic                  neg_r;
  logic                  wrap_r;
  logic                  missing_r;
  logic [SAMPLE_W-1:0]   res_r;

  logic                  out_valid_r;
  cma_out_t              out_data_r;

  logic                  in_fire;
  logic                  load_out;
  logic [DIVISOR_W-1:0]  total;
  logic                  one_empty;
  logic                  plain;
  logic [DIVIDEND_W-1:0] sum_both;
  logic [DIVIDEND_W-1:0] fold;

  assign in_fire   = in_valid && !in_stall;
  assign total     = {1'b0, acc_sts.low_count} + {1'b0, acc_sts.high_count};
  assign one_empty = (acc_sts.low_count == '0) || (acc_sts.high_count == '0);
  // 2*(hs*lc - ls*hc) < m*hc*lc, or the difference is negative
  assign plain     = neg_r || ({diff_r, 1'b0} < {1'b0, prod_r});
  assign sum_both  = {2'b0, acc_sts.low_sum} + {2'b0, acc_sts.high_sum};
  assign load_out  = (state_r == S_OUT) && (!out_valid_r || !out_stall);
  assign fold      = (wrap_r && (div_quotient >= {{(DIVIDEND_W-SAMPLE_W){1'b0}}, modulus_r}))
                     ? div_quotient - {{(DIVIDEND_W-SAMPLE_W){1'b0}}, modulus_r}
                     : div_quotient;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (in_fire && in_data.end_of_window) state_nxt = S_CHECK;
      S_CHECK: begin
        if (total == '0) begin
          state_nxt = S_OUT;
        end else if (one_empty) begin
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_MUL_HL;
        end
      end
      S_MUL_HL:  state_nxt = S_MUL_LH;
      S_MUL_LH:  state_nxt = S_MUL_MH;
      S_MUL_MH:  state_nxt = S_MUL_MHL;
      S_MUL_MHL: state_nxt = S_CMP;
      S_CMP:     state_nxt = plain ? S_DIV : S_ADDM;
      S_ADDM:    state_nxt = S_DIV;
      S_DIV:     if (div_done) state_nxt = S_OUT;
      S_OUT:     if (load_out) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall     = 1'b1;
    div_start    = 1'b0;
    div_dividend = sum_both;
    div_divisor  = total;
    mul_a        = '0;
    mul_b        = '0;
    case (state_r)
      S_IDLE:    in_stall = 1'b0;
      S_CHECK: begin
        div_start = (total != '0) && one_empty;
        if (acc_sts.low_count == '0) begin
          div_dividend = {2'b0, acc_sts.high_sum};
          div_divisor  = {1'b0, acc_sts.high_count};
        end else begin
          div_dividend = {2'b0, acc_sts.low_sum};
          div_divisor  = {1'b0, acc_sts.low_count};
        end
      end
      S_MUL_HL: begin
        mul_a = acc_sts.high_sum;
        mul_b = acc_sts.low_count;
      end
      S_MUL_LH: begin
        mul_a = acc_sts.low_sum;
        mul_b = acc_sts.high_count;
      end
      S_MUL_MH: begin
        mul_a = {{(SUM_W-SAMPLE_W){1'b0}}, modulus_r};
        mul_b = acc_sts.high_count;
      end
      S_MUL_MHL: begin
        mul_a = prod_r[SUM_W-1:0];
        mul_b = acc_sts.low_count;
      end
      S_CMP: begin
        div_start = plain;
        mul_a     = {{(SUM_W-SAMPLE_W){1'b0}}, modulus_r};
        mul_b     = acc_sts.low_count;
      end
      S_ADDM: begin
        div_start    = 1'b1;
        div_dividend = sum_both + {2'b0, prod_r[SUM_W-1:0]};
      end
      S_DIV:     in_stall = 1'b1;
      S_OUT:     in_stall = 1'b1;
      default:   in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      modulus_r   <= MODULUS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        modulus_r <= cfg_wr_data;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // shared multiplier, product registered every cycle
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
    case (state_r)
      S_CHECK: begin
        wrap_r    <= 1'b0;
        missing_r <= (total == '0);
        res_r     <= '0;
      end
      S_MUL_LH:  a_r <= prod_r;
      S_MUL_MH: begin
        neg_r  <= a_r < prod_r;
        diff_r <= a_r - prod_r;
      end
      S_CMP:     wrap_r <= !plain;
      S_DIV:     if (div_done) res_r <= fold[SAMPLE_W-1:0];
      default:   ;
    endcase
    if (load_out) begin
      out_data_r.mean_value   <= res_r;
      out_data_r.mean_missing <= missing_r;
    end
  end

  assign acc_ctl.integrate = in_fire && in_data.sample_accepted;
  assign acc_ctl.clear     = load_out;
  assign acc_ctl.sample    = in_data.sample;

  cma_accum u_accum (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (acc_ctl),
    .modulus (modulus_r),
    .sts     (acc_sts)
  );

  cma_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `CMA_ASSERT_NEXT(a_eow_starts_seq, clk, rst_n, in_fire && in_data.end_of_window,
    state_r == S_CHECK, "end-of-window item did not start the result sequence")
  `CMA_ASSERT_NOW(a_div_done_in_div, clk, rst_n, div_done,
    state_r == S_DIV, "divider finished outside the divide step")
  `CMA_ASSERT_NOW(a_idle_div_quiet, clk, rst_n, state_r == S_IDLE,
    !div_busy, "divider busy while idle")
  `CMA_ASSERT_NEXT(a_load_clears, clk, rst_n, load_out,
    acc_sts.low_count == '0 && acc_sts.high_count == '0 && out_valid_r,
    "store not cleared or result not shown after load")

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Circular mean accumulator testbench
// Drives sample items with random bursts and gaps, predicts each window mean
// in a local copy of the accumulators and checks every result item in order.
// Covers group split, unwrap and fold, empty windows, long back-to-back
// windows, modulus extremes and long output back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
  import cma_pkg::*;

  localparam int RESET_CYCLES  = 9;
  localparam int IDLE_LIMIT    = 3000;
  localparam int SETTLE_CYCLES = 64;
  localparam int LONG_HOLD     = 400;
  localparam int RANDOM_ITEMS  = 1700;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                in_valid    = 1'b0;
  logic                in_stall;
  cma_in_t             in_data     = '0;
  logic                out_valid;
  logic                out_stall   = 1'b0;
  cma_out_t            out_data;
  logic                cfg_wr_en   = 1'b0;
  logic [SAMPLE_W-1:0] cfg_wr_data = MODULUS_RESET;

  circular_mean_accumulator_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // local copy of the block state
  logic [SAMPLE_W-1:0] modulus_q    = MODULUS_RESET;
  logic [SUM_W-1:0]    low_sum_q    = '0;
  logic [SUM_W-1:0]    high_sum_q   = '0;
  logic [COUNT_W-1:0]  low_count_q  = '0;
  logic [COUNT_W-1:0]  high_count_q = '0;

  cma_out_t expected_means[$];
  int       err_count  = 0;
  bit       idle_en    = 1'b1;
  int       burst_left = 0;
  bit       hold_req   = 1'b0;

  function automatic cma_out_t window_mean();
    cma_out_t        res;
    longint unsigned ls, hs, lc, hc, m, n, r;
    longint          diff;
    ls = low_sum_q;
    hs = high_sum_q;
    lc = low_count_q;
    hc = high_count_q;
    m  = modulus_q;
    n  = lc + hc;
    if (n == 0) begin
      res.mean_value   = '0;
      res.mean_missing = 1'b1;
      return res;
    end
    if (lc == 0) begin
      r = hs / hc;
    end else if (hc == 0) begin
      r = ls / lc;
    end else begin
      // exact comparison of the two group means, cross-multiplied
      diff = $signed(hs * lc) - $signed(ls * hc);
      if (diff < 0 || $unsigned(diff) * 2 < m * hc * lc) begin
        r = (ls + hs) / n;
      end else begin
        r = (ls + hs + m * lc) / n;
        if (r >= m) r = r - m;
      end
    end
    res.mean_value   = r[SAMPLE_W-1:0];
    res.mean_missing = 1'b0;
    return res;
  endfunction

  task automatic predict_item(input cma_in_t it);
    int unsigned twice;
    twice = 2 * it.sample;
    if (it.sample_accepted) begin
      if (twice < modulus_q) begin
        if (low_count_q < MAX_SAMPLES) begin
          low_count_q = low_count_q + 1'b1;
          low_sum_q   = low_sum_q + it.sample;
        end
      end else begin
        if (high_count_q < MAX_SAMPLES) begin
          high_count_q = high_count_q + 1'b1;
          high_sum_q   = high_sum_q + it.sample;
        end
      end
    end
    if (it.end_of_window) begin
      expected_means.push_back(window_mean());
      low_sum_q    = '0;
      high_sum_q   = '0;
      low_count_q  = '0;
      high_count_q = '0;
    end
  endtask

  // valid stays high on return; caller offers the next item or lowers it
  task automatic send_item(input cma_in_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(it);
  endtask

  task automatic offer(input logic [SAMPLE_W-1:0] s, input bit acc, input bit eow);
    cma_in_t it;
    it.sample          = s;
    it.sample_accepted = acc;
    it.end_of_window   = eow;
    send_item(it);
    if (idle_en) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 30);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_modulus(input logic [SAMPLE_W-1:0] m);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    modulus_q = m;
  endtask

  // result checker
  always @(posedge clk) begin
    cma_out_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_means.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result item, expected=none actual value=%0d missing=%0b",
                 $time, out_data.mean_value, out_data.mean_missing);
      end else begin
        exp_res = expected_means.pop_front();
        if (out_data.mean_value !== exp_res.mean_value) begin
          err_count++;
          $display("%0t: mean_value mismatch, expected=%0d actual=%0d",
                   $time, exp_res.mean_value, out_data.mean_value);
        end
        if (out_data.mean_missing !== exp_res.mean_missing) begin
          err_count++;
          $display("%0t: mean_missing mismatch, expected=%0b actual=%0b",
                   $time, exp_res.mean_missing, out_data.mean_missing);
        end
      end
    end
  end

  // receiver stall pattern, with an on-demand long hold-off
  int hold_left = 0;
  int stall_mode = 0;
  int mode_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 2);
          mode_left  = $urandom_range(20, 200);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // watchdog on cycles without any transfer
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en || !rst_n) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic test_default_modulus();
    // empty windows
    offer(16'd0, 1'b0, 1'b1);
    offer(16'd500, 1'b0, 1'b0);
    offer(16'd200, 1'b0, 1'b1);
    // single group
    offer(16'd10, 1'b1, 1'b1);
    offer(16'd350, 1'b1, 1'b1);
    // wrap across zero, fold back to zero
    offer(16'd350, 1'b1, 1'b0);
    offer(16'd10, 1'b1, 1'b1);
    // plain mean
    offer(16'd100, 1'b1, 1'b0);
    offer(16'd200, 1'b1, 1'b1);
    // split point and truncation
    offer(16'd179, 1'b1, 1'b0);
    offer(16'd180, 1'b1, 1'b1);
    // sample beyond modulus
    offer(16'hFFFF, 1'b1, 1'b0);
    offer(16'd0, 1'b1, 1'b1);
    offer(16'd0, 1'b1, 1'b1);
  endtask

  task automatic test_modulus_extremes();
    set_modulus(16'd2);
    offer(16'd0, 1'b1, 1'b0);
    offer(16'd1, 1'b1, 1'b1);
    offer(16'hFFFF, 1'b1, 1'b0);
    offer(16'hAAAA, 1'b1, 1'b0);
    offer(16'h5555, 1'b1, 1'b1);
    set_modulus(16'hFFFF);
    offer(16'd0, 1'b1, 1'b0);
    offer(16'd65534, 1'b1, 1'b1);
    offer(16'd32767, 1'b1, 1'b0);
    offer(16'd32768, 1'b1, 1'b0);
    offer(16'hFFFF, 1'b1, 1'b1);
    // odd modulus: half period is not an integer
    set_modulus(16'd361);
    offer(16'd180, 1'b1, 1'b0);
    offer(16'd181, 1'b1, 1'b1);
  endtask

  task automatic test_long_window();
    set_modulus(16'hFFFF);
    idle_en = 1'b0;
    for (int i = 0; i < 100; i++) offer(SAMPLE_W'($urandom_range(0, 32767)), 1'b1, 1'b0);
    for (int i = 0; i < 100; i++) offer(SAMPLE_W'($urandom_range(32768, 65535)), 1'b1, 1'b0);
    offer(16'd100, 1'b1, 1'b1);
    // next window starts from clean counts
    offer(16'd7, 1'b1, 1'b1);
    idle_en = 1'b1;
  endtask

  task automatic test_output_backpressure();
    set_modulus(MODULUS_RESET);
    idle_en  = 1'b0;
    hold_req = 1'b1;
    for (int w = 0; w < 6; w++) begin
      offer(SAMPLE_W'($urandom_range(0, 359)), 1'b1, 1'b0);
      offer(SAMPLE_W'($urandom_range(0, 359)), 1'b1, 1'b0);
      offer(SAMPLE_W'($urandom_range(0, 359)), 1'b1, 1'b1);
    end
    idle_en = 1'b1;
    // sender holds until the whole backlog has drained
    wait_idle();
  endtask

  task automatic send_random_window(output int counted);
    int          len;
    int          kind;
    int unsigned m, c, spread, s;
    bit          acc, eow;
    m      = modulus_q;
    kind   = $urandom_range(0, 9);
    len    = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    c      = $urandom_range(0, m - 1);
    spread = (m / 8 > 1) ? m / 8 : 1;
    counted = 0;
    for (int i = 0; i < len; i++) begin
      case (kind)
        0: s = $urandom_range(0, 65535);
        1, 2, 3: s = (c + m - spread + $urandom_range(0, 2 * spread)) % m;
        4: s = (m >> 1) + $urandom_range(0, 2) - 1;
        default: s = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 65535)
                                                  : $urandom_range(0, m - 1);
      endcase
      acc = (kind == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 9) != 0);
      // noise windows often stay open and merge into the next one
      eow = (i == len - 1) && !(kind == 0 && $urandom_range(0, 3) != 0);
      counted++;
      offer(s[SAMPLE_W-1:0], acc, eow);
    end
  endtask

  task automatic test_random_windows();
    logic [SAMPLE_W-1:0] moduli[8];
    int                  sent, n;
    moduli[0] = 16'd360;
    moduli[1] = 16'd2;
    moduli[2] = 16'd3;
    moduli[3] = 16'hFFFF;
    moduli[4] = 16'd361;
    moduli[5] = SAMPLE_W'($urandom_range(2, 65535));
    moduli[6] = SAMPLE_W'($urandom_range(2, 40));
    moduli[7] = 16'd360;
    for (int p = 0; p < 8; p++) begin
      set_modulus(moduli[p]);
      sent = 0;
      while (sent < RANDOM_ITEMS / 8) begin
        send_random_window(n);
        sent += n;
      end
      // close any window left open by noise
      offer(SAMPLE_W'($urandom_range(0, 65535)), 1'b0, 1'b1);
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_modulus();
    test_modulus_extremes();
    test_long_window();
    test_output_backpressure();
    test_random_windows();
    wait_idle();
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
